/* hdl/dnle_pkg.sv */
// constants shared by the dns name label encoder files
// no dependencies
`timescale 1ns / 1ps

package dnle_pkg;

   localparam int BYTE_W      = 8;
   localparam int MAX_LABEL   = 63;
   localparam int STORE_DEPTH = 63;
   localparam int ADDR_W      = 6;
   localparam int USER_W      = 3;

   // longest label that the store can hold
   localparam int LABEL_LIMIT = (MAX_LABEL < STORE_DEPTH) ? MAX_LABEL : STORE_DEPTH;
   // a final dot keeps the label it closes plus the root byte within 64 bytes
   localparam int ROOT_KEEP   = 62;

   localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;

endpackage

/* hdl/dnle_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module dnle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // read data holds until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/dns_name_label_encoder_top.sv */
// top level of the dns name label encoder
// depends on dnle_pkg and dnle_ram
`timescale 1ns / 1ps

// Usage:
// The req channel takes a dotted name one character a beat: req_tdata is the
// character, req_tlast marks the last character of the name. The rsp channel
// gives the wire form one byte a beat: each label as a length byte followed
// by its characters, a final dot adding a zero root byte.
// Characters are held in a 63-entry label ram until their label closes.
// An ordinary character is taken in and gives no beat. A character that
// closes a label (a dot or the last character) starts a read-out that holds
// off req_tready: the length byte, then each stored character streamed from
// the ram (each read is issued ahead of its byte), then a root byte if the
// name ended in a dot.
// A stall on rsp_tready holds the output register and the read-out; no beat
// is lost. Reset clears the state, the label fill count, the overflow flag and the
// output valid; the ram needs no clearing, only written entries are read.

module dns_name_label_encoder_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dnle_pkg::BYTE_W-1:0]      req_tdata,  // char_byte
   input  logic                             req_tlast,  // final_char
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dnle_pkg::BYTE_W-1:0]      rsp_tdata,  // out_byte
   output logic                             rsp_tlast,  // run_last
   // is_length_byte, name_last, label_too_long
   output logic [dnle_pkg::USER_W-1:0]      rsp_tuser
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LEN  = 2'd1;
   localparam logic [1:0] S_CHAR = 2'd2;
   localparam logic [1:0] S_ROOT = 2'd3;

   localparam logic [dnle_pkg::ADDR_W-1:0] LIMIT = dnle_pkg::ADDR_W'(dnle_pkg::LABEL_LIMIT);
   localparam logic [dnle_pkg::ADDR_W-1:0] KEEP  = dnle_pkg::ADDR_W'(dnle_pkg::ROOT_KEEP);

   logic [1:0] state_ff, state_in;
   logic [dnle_pkg::ADDR_W-1:0] fill_ff, fill_in;
   logic overflow_ff, overflow_in;
   logic [dnle_pkg::ADDR_W-1:0] count_ff, count_in;
   logic [dnle_pkg::ADDR_W-1:0] idx_ff, idx_in;
   logic run_ff, run_in;
   logic name_ff, name_in;
   logic root_ff, root_in;
   logic cut_ff, cut_in;

   logic out_valid_ff, out_valid_in;
   logic [dnle_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic out_len_ff, out_len_in;
   logic out_run_ff, out_run_in;
   logic out_name_ff, out_name_in;
   logic out_cut_ff, out_cut_in;

   logic accept, is_dot, has_room, out_free, load;
   logic wr_en, rd_en;
   logic [dnle_pkg::ADDR_W-1:0] rd_addr;
   logic [dnle_pkg::BYTE_W-1:0] rd_data;
   logic [dnle_pkg::ADDR_W-1:0] fill_next;
   logic ov_next;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_dot     = (req_tdata == dnle_pkg::DOT_CHAR);
   assign has_room   = (fill_ff < LIMIT);
   assign out_free   = !out_valid_ff || rsp_tready;
   assign wr_en      = accept && !is_dot && has_room;
   assign fill_next  = has_room ? dnle_pkg::ADDR_W'(fill_ff + 1'b1) : fill_ff;
   assign ov_next    = overflow_ff || !has_room;

   dnle_ram #(
      .WIDTH(dnle_pkg::BYTE_W),
      .DEPTH(dnle_pkg::STORE_DEPTH)
   ) u_label_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(fill_ff),
      .wr_data(req_tdata),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      overflow_in = overflow_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      run_in      = run_ff;
      name_in     = name_ff;
      root_in     = root_ff;
      cut_in      = cut_ff;
      rd_en       = 1'b0;
      rd_addr     = '0;
      load        = 1'b0;
      out_byte_in = out_byte_ff;
      out_len_in  = out_len_ff;
      out_run_in  = out_run_ff;
      out_name_in = out_name_ff;
      out_cut_in  = out_cut_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (is_dot) begin
                  state_in    = S_LEN;
                  fill_in     = '0;
                  overflow_in = 1'b0;
                  if (req_tlast) begin
                     count_in = (fill_ff > KEEP) ? KEEP : fill_ff;
                     cut_in   = overflow_ff || (fill_ff > KEEP);
                     run_in   = 1'b0;
                     name_in  = 1'b0;
                     root_in  = 1'b1;
                  end else begin
                     count_in = fill_ff;
                     cut_in   = overflow_ff;
                     run_in   = 1'b1;
                     name_in  = 1'b0;
                     root_in  = 1'b0;
                  end
               end else if (req_tlast) begin
                  state_in    = S_LEN;
                  fill_in     = '0;
                  overflow_in = 1'b0;
                  count_in    = fill_next;
                  cut_in      = ov_next;
                  run_in      = 1'b1;
                  name_in     = 1'b1;
                  root_in     = 1'b0;
               end else begin
                  fill_in     = fill_next;
                  overflow_in = ov_next;
               end
            end
         end
         S_LEN: begin
            if (out_free) begin
               load        = 1'b1;
               out_byte_in = dnle_pkg::BYTE_W'(count_ff);
               out_len_in  = 1'b1;
               out_run_in  = (count_ff == '0) && run_ff;
               out_name_in = (count_ff == '0) && name_ff;
               out_cut_in  = cut_ff;
               idx_in      = '0;
               if (count_ff != '0) begin
                  // fetch the first character ahead of its output beat
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_CHAR;
               end else begin
                  state_in = root_ff ? S_ROOT : S_IDLE;
               end
            end
         end
         S_CHAR: begin
            if (out_free) begin
               load        = 1'b1;
               out_byte_in = rd_data;
               out_len_in  = 1'b0;
               out_cut_in  = 1'b0;
               if (dnle_pkg::ADDR_W'(idx_ff + 1'b1) == count_ff) begin
                  out_run_in  = run_ff;
                  out_name_in = name_ff;
                  state_in    = root_ff ? S_ROOT : S_IDLE;
               end else begin
                  out_run_in  = 1'b0;
                  out_name_in = 1'b0;
                  rd_en       = 1'b1;
                  rd_addr     = dnle_pkg::ADDR_W'(idx_ff + 1'b1);
                  idx_in      = dnle_pkg::ADDR_W'(idx_ff + 1'b1);
               end
            end
         end
         S_ROOT: begin
            if (out_free) begin
               load        = 1'b1;
               out_byte_in = '0;
               out_len_in  = 1'b1;
               out_run_in  = 1'b1;
               out_name_in = 1'b1;
               out_cut_in  = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         overflow_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         overflow_ff  <= overflow_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff    <= count_in;
      idx_ff      <= idx_in;
      run_ff      <= run_in;
      name_ff     <= name_in;
      root_ff     <= root_in;
      cut_ff      <= cut_in;
      out_byte_ff <= out_byte_in;
      out_len_ff  <= out_len_in;
      out_run_ff  <= out_run_in;
      out_name_ff <= out_name_in;
      out_cut_ff  <= out_cut_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_run_ff;
   assign rsp_tuser  = {out_cut_ff, out_name_ff, out_len_ff};

endmodule
